### src/sxs_pkg.sv
package sxs_pkg;

  localparam int VALUE_BITS = 30;
  localparam int MAX_ITEMS  = 4096;
  localparam int MAX_NODES  = 122881;

  // Output index fields are fixed at 13 bits.
  localparam int IDX_W  = 13;
  localparam int NODE_W = $clog2(MAX_NODES + 1);
  // Nodes on one level: at most one per stored prefix, ids start at 1.
  localparam int ROW_DEPTH = MAX_ITEMS + 2;
  localparam int LID_W  = $clog2(ROW_DEPTH);
  localparam int LVL_W  = $clog2(VALUE_BITS);
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int NEED_W = $clog2(2 * VALUE_BITS + 1);
  localparam int PADDR_W = 3;

  localparam logic [IDX_W-1:0] LEN_NONE = '1;
  localparam logic [PADDR_W-1:0] REG_THRESHOLD = '0;

  // One trie node: link and latest index for each child slot.
  typedef struct packed {
    logic [LID_W-1:0] l1;
    logic [IDX_W-1:0] m1;
    logic [LID_W-1:0] l0;
    logic [IDX_W-1:0] m0;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Walk token handed from cell to cell.
  typedef struct packed {
    logic                  valid;
    logic                  is_ins;
    logic                  live;
    logic                  fresh;
    logic [LID_W-1:0]      node;
    logic [VALUE_BITS-1:0] key;
    logic [IDX_W-1:0]      pos;
    logic                  hit;
    logic [IDX_W-1:0]      best;
    logic [CNT_W-1:0]      cnt;
  } op_t;

endpackage

### src/sxs_ifs.sv
interface sxs_in_if;
  import sxs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  restart;
  modport source (output valid, value, restart, input ready);
  modport sink (input valid, value, restart, output ready);
endinterface

interface sxs_out_if;
  import sxs_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] best_start;
  logic [IDX_W-1:0] best_end;
  logic             table_full;
  modport source (output valid, found, best_start, best_end, table_full, input ready);
  modport sink (input valid, found, best_start, best_end, table_full, output ready);
endinterface

### src/shortest_xor_at_least_subarray.sv
// Streams values, keeps the running prefix XOR of the current sequence in a
// binary trie and, for each value, reports the shortest subarray so far whose
// XOR reaches the programmed threshold (APB register 0). The trie is a row of
// one cell per bit level, MSB first; each cell owns the node memory of its
// level and passes a walk token to the next cell. In each cell a token is
// registered with its memory read (p1), then updated, written back and
// registered again (op_out). Per item the search walk is issued, then the
// insert walk, with an idle issue slot between them, and the result is
// registered once all its walks have left the row; the next item is taken
// only after that. The first item of a sequence also inserts the zero prefix
// first. An item refused for lack of capacity goes to the result without a
// walk. restart clears the trie at once: new nodes are marked fresh, so no
// clearing pass runs. A result waits in an output register; the next item is
// taken while it waits, and a result stalled by the receiver holds the one
// after it, and with it the input.
module shortest_xor_at_least_subarray (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sxs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  sxs_in_if.sink                     items,
  sxs_out_if.source                  results
);
  import sxs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] threshold;
  logic [VALUE_BITS-1:0] prefix;
  logic [IDX_W-1:0]      idx;
  logic [NODE_W-1:0]     node_count;
  logic [IDX_W-1:0]      best_len;
  logic [IDX_W-1:0]      bstart;
  logic [IDX_W-1:0]      bend;
  logic                  full;
  logic [1:0]            iss_left;
  logic [1:0]            exits_left;
  logic                  gap;
  logic                  clr;
  op_t                   issue_op;
  op_t                   chain [VALUE_BITS+1];

  logic                  accept;
  logic [VALUE_BITS-1:0] eff_prefix;
  logic [IDX_W-1:0]      eff_idx;
  logic [NODE_W-1:0]     eff_nodes;
  logic                  eff_full;
  logic [NEED_W-1:0]     need;
  logic                  refuse;
  logic [IDX_W-1:0]      hit_len;
  op_t                   exit_op;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_THRESHOLD) ? 32'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (psel && penable && pwrite && paddr == REG_THRESHOLD) begin
      threshold <= pwdata[VALUE_BITS-1:0];
    end
  end

  // Row of level cells
  assign chain[0] = issue_op;
  for (genvar g = 0; g < VALUE_BITS; g++) begin : g_cell
    sxs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clr),
      .level   (LVL_W'(VALUE_BITS - 1 - g)),
      .thr_bit (threshold[VALUE_BITS-1-g]),
      .op_in   (chain[g]),
      .op_out  (chain[g+1])
    );
  end
  assign exit_op = chain[VALUE_BITS];

  // Sequence state as seen by the item being accepted (restart applied)
  assign accept     = items.valid && items.ready;
  assign items.ready = (state == ST_IDLE);
  assign eff_prefix = items.restart ? '0 : prefix;
  assign eff_idx    = items.restart ? '0 : idx;
  assign eff_nodes  = items.restart ? '0 : node_count;
  assign eff_full   = items.restart ? 1'b0 : full;
  assign need       = (eff_idx == '0) ? NEED_W'(2 * VALUE_BITS) : NEED_W'(VALUE_BITS);
  assign refuse     = eff_full || (eff_idx >= IDX_W'(MAX_ITEMS)) ||
                      ((NODE_W+1)'(eff_nodes) + (NODE_W+1)'(need) >
                       (NODE_W+1)'(MAX_NODES - 1));
  assign hit_len    = idx - exit_op.best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      prefix         <= '0;
      idx            <= '0;
      node_count     <= '0;
      best_len       <= LEN_NONE;
      bstart         <= '0;
      bend           <= '0;
      full           <= 1'b0;
      iss_left       <= '0;
      exits_left     <= '0;
      gap            <= 1'b0;
      clr            <= 1'b0;
      issue_op.valid <= 1'b0;
      results.valid  <= 1'b0;
    end else begin
      // clear the level allocators when a sequence starts
      clr            <= accept && !refuse && (eff_idx == '0);
      // leave an idle slot between issued walks so a cell never sees two at once
      issue_op.valid <= (state == ST_RUN) && (iss_left != '0) && !gap;
      if (state == ST_DONE && (!results.valid || results.ready)) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (items.restart) begin
              best_len <= LEN_NONE;
              bstart   <= '0;
              bend     <= '0;
            end
            node_count <= eff_nodes;
            full       <= refuse;
            if (refuse) begin
              // drop the item, repeat the current best
              prefix <= eff_prefix;
              idx    <= eff_idx;
              state  <= ST_DONE;
            end else begin
              prefix     <= eff_prefix ^ items.value;
              idx        <= eff_idx + IDX_W'(1);
              iss_left   <= (eff_idx == '0) ? 2'd3 : 2'd2;
              exits_left <= (eff_idx == '0) ? 2'd3 : 2'd2;
              gap        <= 1'b0;
              state      <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (iss_left != '0 && !gap) begin
            iss_left <= iss_left - 2'd1;
            gap      <= 1'b1;
          end else begin
            gap <= 1'b0;
          end
          if (exit_op.valid) begin
            exits_left <= exits_left - 2'd1;
            if (exit_op.is_ins) begin
              node_count <= node_count + NODE_W'(exit_op.cnt);
            end else if (exit_op.hit && hit_len < best_len) begin
              best_len <= hit_len;
              bstart   <= exit_op.best + IDX_W'(1);
              bend     <= idx;
            end
            if (exits_left == 2'd1) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!results.valid || results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk token payload: zero-prefix insert, search, then prefix insert
  always_ff @(posedge clk) begin
    issue_op.is_ins <= (iss_left != 2'd2);
    issue_op.live   <= 1'b1;
    issue_op.fresh  <= (iss_left == 2'd3);
    issue_op.node   <= '0;
    issue_op.key    <= (iss_left == 2'd3) ? '0 : prefix;
    issue_op.pos    <= (iss_left == 2'd3) ? '0 : idx;
    issue_op.hit    <= 1'b0;
    issue_op.best   <= '0;
    issue_op.cnt    <= '0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!results.valid || results.ready)) begin
      results.found      <= (best_len != LEN_NONE);
      results.best_start <= bstart;
      results.best_end   <= bend;
      results.table_full <= full;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted item did not start work");

  a_exit_only_running: assert property (@(posedge clk) disable iff (rst)
    exit_op.valid |-> state == ST_RUN)
    else $error("walk left the cell row outside of a run");

  a_nodes_bounded: assert property (@(posedge clk) disable iff (rst)
    node_count <= NODE_W'(MAX_NODES - 1))
    else $error("node count beyond capacity");

  a_best_ordered: assert property (@(posedge clk) disable iff (rst)
    best_len != LEN_NONE |-> bend >= bstart && bstart != '0)
    else $error("best bounds inconsistent");
endmodule

### src/sxs_ram.sv
module sxs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/sxs_cell.sv
module sxs_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr,
  input  logic [sxs_pkg::LVL_W-1:0] level,
  input  logic                     thr_bit,
  input  sxs_pkg::op_t             op_in,
  output sxs_pkg::op_t             op_out
);
  import sxs_pkg::*;

  op_t              p1;
  op_t              nxt;
  row_t             rd_row;
  row_t             row;
  row_t             wrow;
  logic             we;
  logic             alloc_inc;
  logic [LID_W-1:0] alloc;
  logic [LID_W-1:0] new_id;
  logic             kbit;
  logic             last;
  logic [LID_W-1:0] opp_l;
  logic [LID_W-1:0] same_l;
  logic [IDX_W-1:0] opp_m;
  logic [IDX_W-1:0] same_m;

  sxs_ram #(.WIDTH(ROW_W), .DEPTH(ROW_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (p1.node),
    .wdata (wrow),
    .raddr (op_in.node),
    .rdata (rd_row)
  );

  assign new_id = alloc + LID_W'(1);

  always_comb begin
    // a freshly allocated node has no children yet
    row    = p1.fresh ? '0 : rd_row;
    kbit   = p1.key[level];
    last   = (level == '0);
    opp_l  = kbit ? row.l0 : row.l1;
    opp_m  = kbit ? row.m0 : row.m1;
    same_l = kbit ? row.l1 : row.l0;
    same_m = kbit ? row.m1 : row.m0;
    nxt       = p1;
    wrow      = row;
    we        = 1'b0;
    alloc_inc = 1'b0;
    if (p1.valid && p1.live) begin
      if (p1.is_ins) begin
        we = 1'b1;
        nxt.fresh = 1'b0;
        if (kbit) begin
          wrow.m1 = p1.pos;
          if (row.l1 == '0) begin
            wrow.l1   = new_id;
            alloc_inc = 1'b1;
            nxt.fresh = 1'b1;
          end
          nxt.node = wrow.l1;
        end else begin
          wrow.m0 = p1.pos;
          if (row.l0 == '0) begin
            wrow.l0   = new_id;
            alloc_inc = 1'b1;
            nxt.fresh = 1'b1;
          end
          nxt.node = wrow.l0;
        end
        if (alloc_inc) begin
          nxt.cnt = p1.cnt + CNT_W'(1);
        end
      end else if (thr_bit) begin
        if (opp_l == '0) begin
          nxt.live = 1'b0;
        end else begin
          if (last && (!nxt.hit || opp_m > nxt.best)) begin
            nxt.hit  = 1'b1;
            nxt.best = opp_m;
          end
          nxt.node = opp_l;
        end
      end else begin
        if (opp_l != '0 && (!nxt.hit || opp_m > nxt.best)) begin
          nxt.hit  = 1'b1;
          nxt.best = opp_m;
        end
        if (same_l == '0) begin
          nxt.live = 1'b0;
        end else begin
          if (last && (!nxt.hit || same_m > nxt.best)) begin
            nxt.hit  = 1'b1;
            nxt.best = same_m;
          end
          nxt.node = same_l;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid     <= 1'b0;
      op_out.valid <= 1'b0;
      alloc        <= '0;
    end else begin
      p1.valid     <= op_in.valid;
      op_out.valid <= nxt.valid;
      if (clr) begin
        alloc <= '0;
      end else if (alloc_inc) begin
        alloc <= new_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1.is_ins     <= op_in.is_ins;
    p1.live       <= op_in.live;
    p1.fresh      <= op_in.fresh;
    p1.node       <= op_in.node;
    p1.key        <= op_in.key;
    p1.pos        <= op_in.pos;
    p1.hit        <= op_in.hit;
    p1.best       <= op_in.best;
    p1.cnt        <= op_in.cnt;
    op_out.is_ins <= nxt.is_ins;
    op_out.live   <= nxt.live;
    op_out.fresh  <= nxt.fresh;
    op_out.node   <= nxt.node;
    op_out.key    <= nxt.key;
    op_out.pos    <= nxt.pos;
    op_out.hit    <= nxt.hit;
    op_out.best   <= nxt.best;
    op_out.cnt    <= nxt.cnt;
  end
endmodule
